### design/timed_relay_step_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// timed relay step sequencer assertion macros
// shorthand for clocked implication checks, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef TIMED_RELAY_STEP_SEQUENCER_UNIT_ASSERT_SVH
`define TIMED_RELAY_STEP_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define TRSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TRSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/trss_pkg.sv
// ----------------------------------------------------------------------------
// trss_pkg
// shared types, codes and defaults of the timed relay step sequencer
// ----------------------------------------------------------------------------
package trss_pkg;

  localparam int STEP_COUNT_DEF = 16;

  localparam int DUR_W = 24;
  localparam int REL_W = 6;
  localparam int TOT_W = 32;

  localparam logic [7:0] TICK_MS_RST = 8'd2;

  // register index taken from paddr[2]
  localparam logic REG_TICK_MS = 1'b0;

  // function codes
  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_STOP  = 3'd2;
  localparam logic [2:0] FN_FWD   = 3'd3;
  localparam logic [2:0] FN_BACK  = 3'd4;
  localparam logic [2:0] FN_WRITE = 3'd5;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_STEP    = 2'd1;
  localparam logic [1:0] EV_STOP    = 2'd2;
  localparam logic [1:0] EV_IGNORED = 2'd3;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic [REL_W-1:0] rel;
  } entry_t;

  typedef struct packed {
    logic             running;
    logic [3:0]       current_step;
    logic [REL_W-1:0] relay_bits;
    logic             sync_on;
    logic [TOT_W-1:0] total_time_ms;
    logic [DUR_W-1:0] step_time_ms;
    logic [1:0]       event_res;
  } result_t;

endpackage

### design/trss_prog_ram.sv
// ----------------------------------------------------------------------------
// trss_prog_ram
// program table: one write port, two registered read ports, write bypass
// and per-entry valid bits so unwritten entries read as zero after reset
// ----------------------------------------------------------------------------
module trss_prog_ram #(
  parameter int DEPTH = trss_pkg::STEP_COUNT_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  trss_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr_a,
  input  logic [AW-1:0]   raddr_b,
  output trss_pkg::entry_t rdata_a,
  output trss_pkg::entry_t rdata_b
);

  trss_pkg::entry_t mem [DEPTH];
  trss_pkg::entry_t rd_a;
  trss_pkg::entry_t rd_b;
  trss_pkg::entry_t byp;
  logic [DEPTH-1:0] vld;
  logic             v_a;
  logic             v_b;
  logic             hit_a;
  logic             hit_b;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
    byp  <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      v_a   <= 1'b0;
      v_b   <= 1'b0;
      hit_a <= 1'b0;
      hit_b <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      v_a   <= vld[raddr_a];
      v_b   <= vld[raddr_b];
      hit_a <= we && (waddr == raddr_a);
      hit_b <= we && (waddr == raddr_b);
    end
  end

  // same-edge write wins over the stale array read
  assign rdata_a = hit_a ? byp : (v_a ? rd_a : '0);
  assign rdata_b = hit_b ? byp : (v_b ? rd_b : '0);

endmodule

### design/trss_out_buf.sv
// ----------------------------------------------------------------------------
// trss_out_buf
// two-entry result queue with registered head
// ----------------------------------------------------------------------------
module trss_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  trss_pkg::result_t din,
  output logic              has_room,
  output logic              valid,
  input  logic              ready,
  output trss_pkg::result_t dout
);

  logic [1:0]        cnt;
  trss_pkg::result_t e0;
  trss_pkg::result_t e1;
  logic              pop;

  assign valid    = (cnt != 2'd0);
  assign has_room = (cnt != 2'd2);
  assign pop      = valid && ready;
  assign dout     = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt == 2'd2) begin
        e0 <= e1;
        e1 <= din;
      end else begin
        e0 <= din;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= din;
      end else begin
        e1 <= din;
      end
    end else if (pop) begin
      e0 <= e1;
    end
  end

endmodule

### design/timed_relay_step_sequencer_unit.sv
// ----------------------------------------------------------------------------
// timed_relay_step_sequencer_unit
// runs a stored program of timed steps, each driving six load relays, with
// a sync relay on while the program runs
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  request | req_valid / req_ready  | func, entry_index, entry_duration_ms,
//          |                        | entry_relay_bits
//  result  | res_valid / res_ready  | running, current_step, relay_bits,
//          |                        | sync_on, total_time_ms, step_time_ms,
//          |                        | event_res
//  config  | apb psel/penable/...   | tick_ms at byte address 0
//
//  one request per cycle while req_ready is high; its result is in the queue in the cycle after accept
//  the program table sits in a two-read-port ram whose addresses come from
//  the next step index, so the next and previous entries are always ready
//  req_ready drops only when both result queue slots are full
//  rst clears the sequencer state and sets tick_ms to its default; table valid bits clear on the same edge
//
module timed_relay_step_sequencer_unit #(
  parameter int STEP_COUNT = trss_pkg::STEP_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  func,
  input  logic [3:0]  entry_index,
  input  logic [23:0] entry_duration_ms,
  input  logic [5:0]  entry_relay_bits,
  // result channel
  output logic        res_valid,
  input  logic        res_ready,
  output logic        running,
  output logic [3:0]  current_step,
  output logic [5:0]  relay_bits,
  output logic        sync_on,
  output logic [31:0] total_time_ms,
  output logic [23:0] step_time_ms,
  output logic [1:0]  event_res
);

  localparam int IDX_W = $clog2(STEP_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STEP_COUNT - 1);

  // sequencer state
  logic [7:0]       tick_ms;
  logic [IDX_W-1:0] step_index, step_index_next;
  logic [23:0]      step_elapsed, step_elapsed_next;
  logic [31:0]      total_elapsed, total_elapsed_next;
  logic             run_flag, run_flag_next;
  logic [5:0]       relay_drive, relay_drive_next;
  logic             sync_drive, sync_drive_next;
  // duration of the current step and a copy of entry 0, kept in step with the table
  logic [23:0]      cur_dur, cur_dur_next;
  trss_pkg::entry_t first_ent, first_ent_next;

  // table access
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  trss_pkg::entry_t tbl_wdata;
  logic [IDX_W-1:0] addr_next, addr_prev;
  trss_pkg::entry_t rd_next, rd_prev;

  logic              accept;
  logic              buf_room;
  logic [24:0]       se_sum;
  logic [23:0]       se_sat;
  logic              at_last;
  logic              idx_ok;
  logic [1:0]        ev;
  trss_pkg::result_t res_d;
  trss_pkg::result_t res_q;

  // configuration port, writes land on the access phase
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ms <= trss_pkg::TICK_MS_RST;
    end else if (psel && penable && pwrite && (paddr[2] == trss_pkg::REG_TICK_MS)) begin
      tick_ms <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == trss_pkg::REG_TICK_MS) ? {24'd0, tick_ms} : 32'd0;

  // request side
  assign req_ready = buf_room;
  assign accept    = req_valid && req_ready;

  // step timer grows by tick_ms and saturates at all ones
  assign se_sum  = {1'b0, step_elapsed} + {17'd0, tick_ms};
  assign se_sat  = se_sum[24] ? '1 : se_sum[23:0];
  assign at_last = (step_index == LAST_IDX);
  assign idx_ok  = ({28'd0, entry_index} < 32'(STEP_COUNT));

  assign tbl_waddr = IDX_W'(entry_index);
  assign tbl_wdata = '{dur: entry_duration_ms, rel: entry_relay_bits};

  always_comb begin
    step_index_next    = step_index;
    step_elapsed_next  = step_elapsed;
    total_elapsed_next = total_elapsed;
    run_flag_next      = run_flag;
    relay_drive_next   = relay_drive;
    sync_drive_next    = sync_drive;
    cur_dur_next       = cur_dur;
    first_ent_next     = first_ent;
    tbl_we             = 1'b0;
    ev                 = trss_pkg::EV_NONE;
    if (accept) begin
      case (func)
        trss_pkg::FN_TICK: begin
          if (run_flag) begin
            total_elapsed_next = total_elapsed + {24'd0, tick_ms};
            step_elapsed_next  = se_sat;
            if (se_sat >= cur_dur) begin
              // end of table or zero duration ends the program
              if (at_last || (rd_next.dur == '0)) begin
                run_flag_next    = 1'b0;
                relay_drive_next = '0;
                sync_drive_next  = 1'b0;
                ev               = trss_pkg::EV_STOP;
              end else begin
                step_index_next   = step_index + IDX_W'(1);
                step_elapsed_next = '0;
                relay_drive_next  = rd_next.rel;
                cur_dur_next      = rd_next.dur;
                ev                = trss_pkg::EV_STEP;
              end
            end
          end
        end
        trss_pkg::FN_START: begin
          if (run_flag) begin
            ev = trss_pkg::EV_IGNORED;
          end else begin
            total_elapsed_next = '0;
            step_index_next    = '0;
            cur_dur_next       = first_ent.dur;
            if (first_ent.dur == '0) begin
              // empty program, step timer keeps its value
              relay_drive_next = '0;
              sync_drive_next  = 1'b0;
              ev               = trss_pkg::EV_STOP;
            end else begin
              run_flag_next     = 1'b1;
              sync_drive_next   = 1'b1;
              step_elapsed_next = '0;
              relay_drive_next  = first_ent.rel;
              ev                = trss_pkg::EV_STEP;
            end
          end
        end
        trss_pkg::FN_STOP: begin
          run_flag_next    = 1'b0;
          relay_drive_next = '0;
          sync_drive_next  = 1'b0;
          ev               = trss_pkg::EV_STOP;
        end
        trss_pkg::FN_FWD: begin
          if (!run_flag && !at_last && (rd_next.dur != '0)) begin
            step_index_next  = step_index + IDX_W'(1);
            relay_drive_next = rd_next.rel;
            cur_dur_next     = rd_next.dur;
            ev               = trss_pkg::EV_STEP;
          end else begin
            ev = trss_pkg::EV_IGNORED;
          end
        end
        trss_pkg::FN_BACK: begin
          if (!run_flag && (step_index != '0)) begin
            step_index_next  = step_index - IDX_W'(1);
            relay_drive_next = rd_prev.rel;
            cur_dur_next     = rd_prev.dur;
            ev               = trss_pkg::EV_STEP;
          end else begin
            ev = trss_pkg::EV_IGNORED;
          end
        end
        trss_pkg::FN_WRITE: begin
          if (!run_flag && idx_ok) begin
            tbl_we = 1'b1;
            // keep the shadow copies coherent with the table
            if (tbl_waddr == step_index) begin
              cur_dur_next = entry_duration_ms;
            end
            if (entry_index == 4'd0) begin
              first_ent_next = tbl_wdata;
            end
          end else begin
            ev = trss_pkg::EV_IGNORED;
          end
        end
        default: begin
          ev = trss_pkg::EV_IGNORED;
        end
      endcase
    end
  end

  // read addresses follow the next step index, so after the edge the ram
  // outputs hold the neighbors of the step that is current then
  assign addr_next = (step_index_next == LAST_IDX) ? '0 : step_index_next + IDX_W'(1);
  assign addr_prev = (step_index_next == '0) ? LAST_IDX : step_index_next - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index    <= '0;
      step_elapsed  <= '0;
      total_elapsed <= '0;
      run_flag      <= 1'b0;
      relay_drive   <= '0;
      sync_drive    <= 1'b0;
      cur_dur       <= '0;
      first_ent     <= '0;
    end else begin
      step_index    <= step_index_next;
      step_elapsed  <= step_elapsed_next;
      total_elapsed <= total_elapsed_next;
      run_flag      <= run_flag_next;
      relay_drive   <= relay_drive_next;
      sync_drive    <= sync_drive_next;
      cur_dur       <= cur_dur_next;
      first_ent     <= first_ent_next;
    end
  end

  trss_prog_ram #(
    .DEPTH (STEP_COUNT)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .we      (tbl_we),
    .waddr   (tbl_waddr),
    .wdata   (tbl_wdata),
    .raddr_a (addr_next),
    .raddr_b (addr_prev),
    .rdata_a (rd_next),
    .rdata_b (rd_prev)
  );

  // result reflects the state after this request
  always_comb begin
    res_d.running       = run_flag_next;
    res_d.current_step  = 4'(step_index_next);
    res_d.relay_bits    = relay_drive_next;
    res_d.sync_on       = sync_drive_next;
    res_d.total_time_ms = total_elapsed_next;
    res_d.step_time_ms  = step_elapsed_next;
    res_d.event_res     = ev;
  end

  trss_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .din      (res_d),
    .has_room (buf_room),
    .valid    (res_valid),
    .ready    (res_ready),
    .dout     (res_q)
  );

  assign running       = res_q.running;
  assign current_step  = res_q.current_step;
  assign relay_bits    = res_q.relay_bits;
  assign sync_on       = res_q.sync_on;
  assign total_time_ms = res_q.total_time_ms;
  assign step_time_ms  = res_q.step_time_ms;
  assign event_res     = res_q.event_res;

endmodule

### design/trss_port_check.sv
// ----------------------------------------------------------------------------
// trss_port_check
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
`include "timed_relay_step_sequencer_unit_assert.svh"

module trss_port_check (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        running,
  input logic [3:0]  current_step,
  input logic [5:0]  relay_bits,
  input logic        sync_on,
  input logic [31:0] total_time_ms,
  input logic [23:0] step_time_ms,
  input logic [1:0]  event_res
);

  // a stalled result holds
  `TRSS_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(event_res) && $stable(total_time_ms) && $stable(step_time_ms) && $stable(current_step), "stalled result changed")

  // sync relay tracks the run state
  `TRSS_ASSERT_IMP(a_sync_run, res_valid, sync_on == running, "sync drive differs from run state")

  // a stop leaves everything off
  `TRSS_ASSERT_IMP(a_stop_off, res_valid && (event_res == trss_pkg::EV_STOP), !running && (relay_bits == 6'd0), "relays still on after stop")

  // entering a step while running restarts the step timer
  `TRSS_ASSERT_IMP(a_step_clr, res_valid && running && (event_res == trss_pkg::EV_STEP), step_time_ms == 24'd0, "step timer not restarted")

endmodule

bind timed_relay_step_sequencer_unit trss_port_check u_port_check (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: timed relay step sequencer testbench
// self-checking bench for timed_relay_step_sequencer_unit. a short table of
// directed requests is followed by random step programs (write, start, ticks,
// manual moves, stray commands) under several tick_ms settings and idle
// patterns; every result is checked field by field against a predictor or, for
// typed directed rows, against fixed reset values with their own event code
module tb;
  import trss_pkg::*;

  localparam int STEPS = STEP_COUNT_DEF;
  localparam logic [2:0] TICK_MS_ADDR = {REG_TICK_MS, 2'b00};
  // unused function codes, the block must ignore them
  localparam logic [2:0] FN_RSVD6 = 3'd6;
  localparam logic [2:0] FN_RSVD7 = 3'd7;
  localparam int PHASES = 6;
  localparam int PHASE_REQUESTS = 300;

  // one row of the directed table; typed rows carry their own event code
  // and expect everything else at its reset value
  typedef struct {
    logic [2:0]  f;
    logic [3:0]  idx;
    logic [23:0] dur;
    logic [5:0]  rel;
    bit          typed;
    logic [1:0]  ev;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  // configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  // request channel
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [2:0]  func = FN_TICK;
  logic [3:0]  entry_index = '0;
  logic [23:0] entry_duration_ms = '0;
  logic [5:0]  entry_relay_bits = '0;
  // result channel
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        running;
  logic [3:0]  current_step;
  logic [5:0]  relay_bits;
  logic        sync_on;
  logic [31:0] total_time_ms;
  logic [23:0] step_time_ms;
  logic [1:0]  event_res;

  // predicted copy of the sequencer
  logic [23:0] prog_dur [STEPS];
  logic [5:0]  prog_relay [STEPS];
  int unsigned cur_step;
  logic [23:0] step_ms;
  logic [31:0] total_ms;
  bit          run_on;
  logic [5:0]  relay_out;
  bit          sync_out;
  logic [7:0]  tick_ms_cfg;

  // expectation that travels with the request on the bus
  result_t     req_expect = '0;
  result_t     pending_results [$];
  result_t     want;
  result_t     got;

  int sender_idle_pct = 23;
  int receiver_idle_pct = 61;
  int error_count = 0;
  int sent_count = 0;
  int results_checked = 0;
  int useful_count = 0;
  int step_advances = 0;
  int programs_done = 0;
  int table_end_runs = 0;

  timed_relay_step_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .func(func),
    .entry_index(entry_index),
    .entry_duration_ms(entry_duration_ms),
    .entry_relay_bits(entry_relay_bits),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .running(running),
    .current_step(current_step),
    .relay_bits(relay_bits),
    .sync_on(sync_on),
    .total_time_ms(total_time_ms),
    .step_time_ms(step_time_ms),
    .event_res(event_res)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the predicted state, returns the result
  // ---------------------------------------------------------------------------
  function automatic result_t sequencer_next(input logic [2:0] f, input logic [3:0] idx,
                                             input logic [23:0] dur, input logic [5:0] rel);
    result_t     r;
    logic [1:0]  ev;
    logic [24:0] sum;
    int unsigned nxt;
    ev = EV_NONE;
    case (f)
      FN_TICK: begin
        if (run_on) begin
          total_ms = total_ms + 32'(tick_ms_cfg);
          sum = {1'b0, step_ms} + 25'(tick_ms_cfg);
          // step timer saturates instead of wrapping
          step_ms = sum[24] ? 24'hFFFFFF : sum[23:0];
          if (step_ms >= prog_dur[cur_step]) begin
            nxt = cur_step + 1;
            if (nxt >= STEPS || prog_dur[nxt] == '0) begin
              run_on = 1'b0;
              relay_out = '0;
              sync_out = 1'b0;
              ev = EV_STOP;
            end else begin
              cur_step = nxt;
              step_ms = '0;
              relay_out = prog_relay[nxt];
              ev = EV_STEP;
            end
          end
        end
      end
      FN_START: begin
        if (run_on) begin
          ev = EV_IGNORED;
        end else begin
          total_ms = '0;
          cur_step = 0;
          // empty program: stops at once, step timer keeps its value
          if (prog_dur[0] == '0) begin
            relay_out = '0;
            sync_out = 1'b0;
            ev = EV_STOP;
          end else begin
            run_on = 1'b1;
            sync_out = 1'b1;
            step_ms = '0;
            relay_out = prog_relay[0];
            ev = EV_STEP;
          end
        end
      end
      FN_STOP: begin
        run_on = 1'b0;
        relay_out = '0;
        sync_out = 1'b0;
        ev = EV_STOP;
      end
      FN_FWD: begin
        if (!run_on && cur_step + 1 < STEPS && prog_dur[cur_step + 1] != '0) begin
          cur_step = cur_step + 1;
          relay_out = prog_relay[cur_step];
          ev = EV_STEP;
        end else begin
          ev = EV_IGNORED;
        end
      end
      FN_BACK: begin
        if (!run_on && cur_step > 0) begin
          cur_step = cur_step - 1;
          relay_out = prog_relay[cur_step];
          ev = EV_STEP;
        end else begin
          ev = EV_IGNORED;
        end
      end
      FN_WRITE: begin
        // every 4-bit index is inside a 16-entry table
        if (!run_on && int'(idx) < STEPS) begin
          prog_dur[idx] = dur;
          prog_relay[idx] = rel;
        end else begin
          ev = EV_IGNORED;
        end
      end
      default: ev = EV_IGNORED;
    endcase
    r.running = run_on;
    r.current_step = cur_step[3:0];
    r.relay_bits = relay_out;
    r.sync_on = sync_out;
    r.total_time_ms = total_ms;
    r.step_time_ms = step_ms;
    r.event_res = ev;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, seen, wanted);
    error_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] seen,
                             input logic [31:0] wanted);
    if (seen !== wanted) report_mismatch(what, seen, wanted);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: predicts at issue, expectation rides along with the payload
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [2:0] f, input logic [3:0] idx,
                              input logic [23:0] dur, input logic [5:0] rel,
                              input bit typed, input logic [1:0] typed_ev);
    result_t predicted;
    result_t fixed;
    predicted = sequencer_next(f, idx, dur, rel);
    fixed = '0;
    fixed.event_res = typed_ev;
    // random gaps before the request goes up
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    func <= f;
    entry_index <= idx;
    entry_duration_ms <= dur;
    entry_relay_bits <= rel;
    req_expect <= typed ? fixed : predicted;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent_count++;
    if (predicted.event_res != EV_IGNORED) useful_count++;
    if (predicted.event_res == EV_STEP) step_advances++;
    if (f == FN_TICK && predicted.event_res == EV_STOP) begin
      programs_done++;
      if (cur_step == STEPS - 1) table_end_runs++;
    end
  endtask

  // hold requests back until every result has been seen
  task automatic drain_results();
    req_valid <= 1'b0;
    while (results_checked != sent_count) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write of tick_ms: setup cycle, then access cycle
  task automatic write_tick_ms(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TICK_MS_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tick_ms_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // random episodes
  // ---------------------------------------------------------------------------
  // well-formed program: load entries, start, tick it through with stray
  // commands mixed in, then walk around with manual moves
  task automatic run_program();
    int          n;
    int          limit;
    int          ticks;
    logic [23:0] d;
    logic [2:0]  f;
    n = ($urandom_range(0, 4) == 0) ? STEPS : $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      // mostly short steps in tick units, now and then a huge one
      if ($urandom_range(0, 9) == 0) d = 24'($urandom_range(1, 24'hFFFFFF));
      else if (tick_ms_cfg == 0) d = 24'($urandom_range(1, 50));
      else d = 24'($urandom_range(1, 4 * tick_ms_cfg));
      send_request(FN_WRITE, 4'(i), d, 6'($urandom), 1'b0, EV_NONE);
    end
    // terminate the program, unless an older entry is left to follow
    if (n < STEPS && $urandom_range(0, 3) != 0)
      send_request(FN_WRITE, 4'(n), 24'd0, 6'($urandom), 1'b0, EV_NONE);
    repeat ($urandom_range(0, 3))
      send_request($urandom_range(0, 1) ? FN_FWD : FN_BACK, 4'($urandom), 24'($urandom),
                   6'($urandom), 1'b0, EV_NONE);
    send_request(FN_START, 4'($urandom), 24'($urandom), 6'($urandom), 1'b0, EV_NONE);
    limit = (tick_ms_cfg == 0) ? 20 : 150;
    ticks = 0;
    while (run_on && ticks < limit) begin
      if ($urandom_range(0, 14) == 0) begin
        // commands that a running program must ignore
        f = ($urandom_range(0, 4) == 0) ? FN_START : 3'($urandom_range(3, 7));
        send_request(f, 4'($urandom), 24'($urandom), 6'($urandom), 1'b0, EV_NONE);
      end else if ($urandom_range(0, 59) == 0) begin
        send_request(FN_STOP, 4'($urandom), 24'($urandom), 6'($urandom), 1'b0, EV_NONE);
      end else begin
        send_request(FN_TICK, 4'($urandom), 24'($urandom), 6'($urandom), 1'b0, EV_NONE);
        ticks++;
      end
    end
    if (run_on)
      send_request(FN_STOP, 4'($urandom), 24'($urandom), 6'($urandom), 1'b0, EV_NONE);
    repeat ($urandom_range(0, 4))
      send_request($urandom_range(0, 1) ? FN_FWD : FN_BACK, 4'($urandom), 24'($urandom),
                   6'($urandom), 1'b0, EV_NONE);
  endtask

  // unstructured requests, any code and any field values
  task automatic run_noise();
    logic [23:0] d;
    repeat ($urandom_range(5, 15)) begin
      d = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(0, 40));
      send_request(3'($urandom_range(0, 7)), 4'($urandom), d, 6'($urandom), 1'b0, EV_NONE);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, expectation bookkeeping and checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) res_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

  always @(posedge clk) begin
    if (!rst) begin
      // request accepted: its expectation joins the store
      if (req_valid && req_ready) pending_results.push_back(req_expect);
      if (res_valid && res_ready) begin
        got.running = running;
        got.current_step = current_step;
        got.relay_bits = relay_bits;
        got.sync_on = sync_on;
        got.total_time_ms = total_time_ms;
        got.step_time_ms = step_time_ms;
        got.event_res = event_res;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding", 32'(got.event_res), '0);
        end else begin
          want = pending_results.pop_front();
          check_field("running", 32'(got.running), 32'(want.running));
          check_field("current_step", 32'(got.current_step), 32'(want.current_step));
          check_field("relay_bits", 32'(got.relay_bits), 32'(want.relay_bits));
          check_field("sync_on", 32'(got.sync_on), 32'(want.sync_on));
          check_field("total_time_ms", got.total_time_ms, want.total_time_ms);
          check_field("step_time_ms", 32'(got.step_time_ms), 32'(want.step_time_ms));
          check_field("event_res", 32'(got.event_res), 32'(want.event_res));
          results_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    logic [7:0] tick_plan [PHASES];
    int goal;

    // predictor starts from the reset state
    for (int i = 0; i < STEPS; i++) begin
      prog_dur[i] = '0;
      prog_relay[i] = '0;
    end
    cur_step = 0;
    step_ms = '0;
    total_ms = '0;
    run_on = 1'b0;
    relay_out = '0;
    sync_out = 1'b0;
    tick_ms_cfg = TICK_MS_RST;

    // directed table, tick_ms still at its reset value
    // typed rows: everything stays at reset, only the event code differs
    dir_rows.push_back('{FN_TICK,  4'd0,  24'd0,       6'd0,     1'b1, EV_NONE});
    dir_rows.push_back('{FN_START, 4'd0,  24'd0,       6'd0,     1'b1, EV_STOP});
    dir_rows.push_back('{FN_FWD,   4'd0,  24'd0,       6'd0,     1'b1, EV_IGNORED});
    dir_rows.push_back('{FN_BACK,  4'd0,  24'd0,       6'd0,     1'b1, EV_IGNORED});
    dir_rows.push_back('{FN_RSVD6, 4'd15, 24'hFFFFFF,  6'h3F,    1'b1, EV_IGNORED});
    dir_rows.push_back('{FN_RSVD7, 4'd0,  24'd0,       6'd0,     1'b1, EV_IGNORED});
    dir_rows.push_back('{FN_STOP,  4'd0,  24'd0,       6'd0,     1'b1, EV_STOP});
    dir_rows.push_back('{FN_WRITE, 4'd15, 24'hFFFFFF,  6'h3F,    1'b1, EV_NONE});
    dir_rows.push_back('{FN_WRITE, 4'd0,  24'd0,       6'd0,     1'b1, EV_NONE});
    // three-step program, then run it through by hand-picked ticks
    dir_rows.push_back('{FN_WRITE, 4'd0,  24'd3,       6'h2A,    1'b0, EV_NONE});
    dir_rows.push_back('{FN_WRITE, 4'd1,  24'd4,       6'h15,    1'b0, EV_NONE});
    dir_rows.push_back('{FN_WRITE, 4'd2,  24'd1,       6'h3F,    1'b0, EV_NONE});
    dir_rows.push_back('{FN_START, 4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    // start, write and forward while running are ignored
    dir_rows.push_back('{FN_START, 4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_WRITE, 4'd3,  24'd5,       6'h01,    1'b0, EV_NONE});
    dir_rows.push_back('{FN_FWD,   4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_TICK,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_TICK,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_TICK,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_TICK,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    // zero duration behind step 2 ends the program
    dir_rows.push_back('{FN_TICK,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    // manual moves while stopped, forward blocked by the terminator
    dir_rows.push_back('{FN_BACK,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_FWD,   4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_FWD,   4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});
    dir_rows.push_back('{FN_STOP,  4'd0,  24'd0,       6'd0,     1'b0, EV_NONE});

    // synchronous reset
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.f, row.idx, row.dur, row.rel, row.typed, row.ev);
    end

    // tick_ms settings per phase: extremes, zero and random values
    tick_plan = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(3, 254)), 8'd17,
                  8'($urandom_range(3, 254))};
    for (int p = 0; p < PHASES; p++) begin
      // idle pattern: sender light / receiver heavy, swapped, then none
      case (p / 2)
        0: begin
          sender_idle_pct = 23;
          receiver_idle_pct = 61;
        end
        1: begin
          sender_idle_pct = 61;
          receiver_idle_pct = 23;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      // register writes only with nothing in flight
      drain_results();
      write_tick_ms(tick_plan[p]);
      goal = sent_count + PHASE_REQUESTS;
      while (sent_count < goal) begin
        if ($urandom_range(0, 5) == 0) run_noise();
        else run_program();
        // sender holds off until the block has answered everything
        if ($urandom_range(0, 11) == 0) drain_results();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 32'(pending_results.size()), '0);

    $display("covered %0d requests, %0d acted on, %0d checked results, %0d step moves",
             sent_count, useful_count, results_checked, step_advances);
    $display("%0d programs ran out, %0d at the last table entry; tick_ms 2,255,1,0,%0d,17,%0d",
             programs_done, table_end_runs, tick_plan[3], tick_plan[5]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(12 * 600000);
    $display("timeout: requests or results stuck, %0d of %0d results seen",
             results_checked, sent_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
